FILE: sv/tcba_pkg.sv
// ----------------------------------------------------------------------------
// tcba_pkg
// Shared types, defaults and codes of the two-class bitmap slot allocator.
// ----------------------------------------------------------------------------
package tcba_pkg;

    // pool geometry defaults
    localparam int SMALL_SLOTS_DEF      = 16;
    localparam int SMALL_SLOT_BYTES_DEF = 64;
    localparam int LARGE_SLOTS_DEF      = 8;
    localparam int LARGE_SLOT_BYTES_DEF = 512;

    localparam int          ADDR_W         = 32;
    localparam int          CFG_IDX_W      = 1;
    localparam logic [31:0] SMALL_BASE_RST = 32'd4096;
    localparam logic [31:0] LARGE_BASE_RST = 32'd8192;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE = 1'd1;

    // request kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // pool classes
    localparam logic CLASS_SMALL = 1'b0;
    localparam logic CLASS_LARGE = 1'b1;

    // result status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_IGNORED = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_HEAP    = 3'd3;
    localparam logic [2:0] ST_FOREIGN = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [31:0] request_size;
        logic [31:0] release_address;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        pool_class;
        logic [3:0]  slot_index;
        logic [31:0] granted_address;
    } t_out_item;

endpackage

FILE: sv/two_class_bitmap_slot_allocator.sv
// ----------------------------------------------------------------------------
// two_class_bitmap_slot_allocator
// Fixed-slot allocator over a small and a large pool, one bitmap per pool.
// ----------------------------------------------------------------------------
// usage
//   request channel: i_in_valid / o_in_stall / i_in_item (kind, size, address)
//   result channel:  o_out_valid / i_out_stall / o_out_item, one result per item
//   an item moves on an edge where valid is high and stall is low
//   config: i_cfg_we writes i_cfg_wdata to pool base i_cfg_index; only while idle, a rule the block leaves to the user
// timing
//   an item is held in the input register, decided combinationally against the
//   bitmaps and written to the result register; one item per cycle sustained
//   while i_out_stall is low; the bitmap update is done in the same cycle as the
//   decision, so back-to-back items see each other's effect
// reset
//   both bitmaps clear (all slots free), bases return to 4096 and 8192,
//   both registers empty
// stall
//   a held result waits in the output register; the input register still takes
//   one more item, then o_in_stall rises until the result is taken
// ----------------------------------------------------------------------------
module two_class_bitmap_slot_allocator #(
    parameter int SMALL_SLOTS      = tcba_pkg::SMALL_SLOTS_DEF,
    parameter int SMALL_SLOT_BYTES = tcba_pkg::SMALL_SLOT_BYTES_DEF,
    parameter int LARGE_SLOTS      = tcba_pkg::LARGE_SLOTS_DEF,
    parameter int LARGE_SLOT_BYTES = tcba_pkg::LARGE_SLOT_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  tcba_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output tcba_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_we,
    input  logic [tcba_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tcba_pkg::ADDR_W-1:0]      i_cfg_wdata
);
    import tcba_pkg::*;

    logic        r_in_valid, r_out_valid;
    t_in_item    r_in_item;
    t_out_item   r_out_item;
    t_out_item   result;
    logic [31:0] r_small_base, r_large_base;
    logic        out_free, fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    tcba_core #(
        .SMALL_SLOTS      (SMALL_SLOTS),
        .SMALL_SLOT_BYTES (SMALL_SLOT_BYTES),
        .LARGE_SLOTS      (LARGE_SLOTS),
        .LARGE_SLOT_BYTES (LARGE_SLOT_BYTES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in_item),
        .i_small_base (r_small_base),
        .i_large_base (r_large_base),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (out_free) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_base <= SMALL_BASE_RST;
            r_large_base <= LARGE_BASE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SMALL_BASE: r_small_base <= i_cfg_wdata;
                CFG_LARGE_BASE: r_large_base <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: sv/tcba_find.sv
// ----------------------------------------------------------------------------
// tcba_find
// Priority encoder: lowest clear bit of an occupancy bitmap.
// ----------------------------------------------------------------------------
module tcba_find #(
    parameter int SLOTS = 16,
    parameter int IW    = 4
) (
    input  logic [SLOTS-1:0] i_map,
    output logic             o_found,
    output logic [IW-1:0]    o_idx
);

    always_comb begin
        o_found = 1'b0;
        o_idx   = '0;
        // walk down so the lowest free slot wins
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!i_map[i]) begin
                o_found = 1'b1;
                o_idx   = IW'(i);
            end
        end
    end

endmodule

FILE: sv/tcba_div.sv
// ----------------------------------------------------------------------------
// tcba_div
// Slot number of a byte offset inside a pool: offset divided by slot size.
// ----------------------------------------------------------------------------
module tcba_div #(
    parameter int SLOTS = 16,
    parameter int BYTES = 64,
    parameter int IW    = 4
) (
    input  logic [31:0]   i_offset,
    output logic [IW-1:0] o_slot
);

    localparam bit BYTES_POW2 = (BYTES & (BYTES - 1)) == 0;
    localparam int SHIFT      = (BYTES > 1) ? $clog2(BYTES) : 0;

    generate
        if (BYTES_POW2) begin : g_shift
            assign o_slot = IW'(i_offset >> SHIFT);
        end else begin : g_window
            // offset is known to be below SLOTS * BYTES: match it to one slot window
            always_comb begin
                o_slot = '0;
                for (int k = 0; k < SLOTS; k++) begin
                    if (i_offset >= 32'(k * BYTES) && i_offset < 32'((k + 1) * BYTES)) begin
                        o_slot = o_slot | IW'(k);
                    end
                end
            end
        end
    endgenerate

endmodule

FILE: sv/tcba_core.sv
// ----------------------------------------------------------------------------
// tcba_core
// Occupancy bitmaps and the allocate / free decision for one item.
// ----------------------------------------------------------------------------
module tcba_core #(
    parameter int SMALL_SLOTS      = 16,
    parameter int SMALL_SLOT_BYTES = 64,
    parameter int LARGE_SLOTS      = 8,
    parameter int LARGE_SLOT_BYTES = 512
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  tcba_pkg::t_in_item   i_item,
    input  logic [31:0]          i_small_base,
    input  logic [31:0]          i_large_base,
    output tcba_pkg::t_out_item  o_result
);
    import tcba_pkg::*;

    localparam int          SIW         = (SMALL_SLOTS > 1) ? $clog2(SMALL_SLOTS) : 1;
    localparam int          LIW         = (LARGE_SLOTS > 1) ? $clog2(LARGE_SLOTS) : 1;
    localparam logic [31:0] SMALL_BYTES = 32'(SMALL_SLOT_BYTES);
    localparam logic [31:0] LARGE_BYTES = 32'(LARGE_SLOT_BYTES);
    localparam logic [31:0] SMALL_SPAN  = 32'(SMALL_SLOTS * SMALL_SLOT_BYTES);
    localparam logic [31:0] LARGE_SPAN  = 32'(LARGE_SLOTS * LARGE_SLOT_BYTES);

    logic [SMALL_SLOTS-1:0] r_small_map, n_small_map;
    logic [LARGE_SLOTS-1:0] r_large_map, n_large_map;

    logic           small_found, large_found;
    logic [SIW-1:0] small_free_idx, small_rel_idx;
    logic [LIW-1:0] large_free_idx, large_rel_idx;
    logic [31:0]    small_offset, large_offset;
    logic           in_small, in_large;
    logic [6:0]     small_wide, large_wide, small_rel_wide, large_rel_wide;

    tcba_find #(.SLOTS(SMALL_SLOTS), .IW(SIW)) u_small_find (
        .i_map   (r_small_map),
        .o_found (small_found),
        .o_idx   (small_free_idx)
    );

    tcba_find #(.SLOTS(LARGE_SLOTS), .IW(LIW)) u_large_find (
        .i_map   (r_large_map),
        .o_found (large_found),
        .o_idx   (large_free_idx)
    );

    assign small_offset = i_item.release_address - i_small_base;
    assign large_offset = i_item.release_address - i_large_base;
    assign in_small     = (i_item.release_address >= i_small_base) && (small_offset < SMALL_SPAN);
    assign in_large     = (i_item.release_address >= i_large_base) && (large_offset < LARGE_SPAN);

    tcba_div #(.SLOTS(SMALL_SLOTS), .BYTES(SMALL_SLOT_BYTES), .IW(SIW)) u_small_div (
        .i_offset (small_offset),
        .o_slot   (small_rel_idx)
    );

    tcba_div #(.SLOTS(LARGE_SLOTS), .BYTES(LARGE_SLOT_BYTES), .IW(LIW)) u_large_div (
        .i_offset (large_offset),
        .o_slot   (large_rel_idx)
    );

    // slot index field carries the low four bits of the index
    assign small_wide     = 7'(small_free_idx);
    assign large_wide     = 7'(large_free_idx);
    assign small_rel_wide = 7'(small_rel_idx);
    assign large_rel_wide = 7'(large_rel_idx);

    always_comb begin
        o_result    = '0;
        n_small_map = r_small_map;
        n_large_map = r_large_map;
        if (i_item.kind == KIND_ALLOC) begin
            if (i_item.request_size == 32'd0) begin
                o_result.status = ST_IGNORED;
            end else if (i_item.request_size <= SMALL_BYTES) begin
                o_result.pool_class = CLASS_SMALL;
                if (!small_found) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_result.status          = ST_DONE;
                    o_result.slot_index      = small_wide[3:0];
                    o_result.granted_address = i_small_base
                                             + 32'(small_free_idx) * SMALL_BYTES;
                    n_small_map[small_free_idx] = 1'b1;
                end
            end else if (i_item.request_size <= LARGE_BYTES) begin
                o_result.pool_class = CLASS_LARGE;
                if (!large_found) begin
                    o_result.status = ST_FULL;
                end else begin
                    o_result.status          = ST_DONE;
                    o_result.slot_index      = large_wide[3:0];
                    o_result.granted_address = i_large_base
                                             + 32'(large_free_idx) * LARGE_BYTES;
                    n_large_map[large_free_idx] = 1'b1;
                end
            end else begin
                o_result.status = ST_HEAP;
            end
        end else begin
            if (i_item.release_address == 32'd0) begin
                o_result.status = ST_IGNORED;
            end else if (in_small) begin
                // small pool wins where the ranges overlap
                o_result.status            = ST_DONE;
                o_result.pool_class        = CLASS_SMALL;
                o_result.slot_index        = small_rel_wide[3:0];
                n_small_map[small_rel_idx] = 1'b0;
            end else if (in_large) begin
                o_result.status            = ST_DONE;
                o_result.pool_class        = CLASS_LARGE;
                o_result.slot_index        = large_rel_wide[3:0];
                n_large_map[large_rel_idx] = 1'b0;
            end else begin
                o_result.status = ST_FOREIGN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_map <= '0;
            r_large_map <= '0;
        end else if (i_fire) begin
            r_small_map <= n_small_map;
            r_large_map <= n_large_map;
        end
    end

endmodule

FILE: tb/tb_two_class_bitmap_slot_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_class_bitmap_slot_allocator
// Self-checking bench for the two-class slot allocator. A shadow copy of both
// occupancy bitmaps and both pool bases predicts every result. Directed items
// come first, then random allocate and free traffic under six pool base
// settings. Sender gaps and receiver stalls are random, but absent in phases 4-5.
// ----------------------------------------------------------------------------
module tb_two_class_bitmap_slot_allocator;
    import tcba_pkg::*;

    localparam int SMALL_SPAN      = SMALL_SLOTS_DEF * SMALL_SLOT_BYTES_DEF;
    localparam int LARGE_SPAN      = LARGE_SLOTS_DEF * LARGE_SLOT_BYTES_DEF;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int BURST_LEN       = 48;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        logic     hold_for_drain;
        t_in_item req;
    } t_pending;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ADDR_W-1:0]    cfg_wdata = '0;
    t_in_item             in_item   = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_item;

    // shadow of the allocator state
    logic [SMALL_SLOTS_DEF-1:0] small_used = '0;
    logic [LARGE_SLOTS_DEF-1:0] large_used = '0;
    logic [31:0]                small_base = SMALL_BASE_RST;
    logic [31:0]                large_base = LARGE_BASE_RST;

    t_pending  request_q[$];
    t_out_item outcome_q[$];

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int requests_total = 0;
    int status_seen[5] = '{0, 0, 0, 0, 0};

    two_class_bitmap_slot_allocator u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic t_out_item predict_outcome(input t_in_item req);
        t_out_item   res;
        int          slot;
        int          i;
        logic [31:0] addr;
        res  = '0;
        slot = -1;
        addr = req.release_address;
        if (req.kind == KIND_ALLOC) begin
            if (req.request_size == 32'd0) begin
                res.status = ST_IGNORED;
            end else if (req.request_size <= SMALL_SLOT_BYTES_DEF) begin
                for (i = SMALL_SLOTS_DEF - 1; i >= 0; i--) begin
                    if (!small_used[i]) slot = i;
                end
                res.pool_class = CLASS_SMALL;
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    small_used[slot]    = 1'b1;
                    res.status          = ST_DONE;
                    res.slot_index      = 4'(slot);
                    res.granted_address = small_base + 32'(slot * SMALL_SLOT_BYTES_DEF);
                end
            end else if (req.request_size <= LARGE_SLOT_BYTES_DEF) begin
                for (i = LARGE_SLOTS_DEF - 1; i >= 0; i--) begin
                    if (!large_used[i]) slot = i;
                end
                res.pool_class = CLASS_LARGE;
                if (slot < 0) begin
                    res.status = ST_FULL;
                end else begin
                    large_used[slot]    = 1'b1;
                    res.status          = ST_DONE;
                    res.slot_index      = 4'(slot);
                    res.granted_address = large_base + 32'(slot * LARGE_SLOT_BYTES_DEF);
                end
            end else begin
                res.status = ST_HEAP;
            end
        end else if (addr == 32'd0) begin
            // null is ignored even when a base sits at zero
            res.status = ST_IGNORED;
        end else if (addr >= small_base && addr - small_base < SMALL_SPAN) begin
            // small pool wins where the two ranges overlap
            slot             = (addr - small_base) / SMALL_SLOT_BYTES_DEF;
            small_used[slot] = 1'b0;
            res.status       = ST_DONE;
            res.pool_class   = CLASS_SMALL;
            res.slot_index   = 4'(slot);
        end else if (addr >= large_base && addr - large_base < LARGE_SPAN) begin
            slot             = (addr - large_base) / LARGE_SLOT_BYTES_DEF;
            large_used[slot] = 1'b0;
            res.status       = ST_DONE;
            res.pool_class   = CLASS_LARGE;
            res.slot_index   = 4'(slot);
        end else begin
            res.status = ST_FOREIGN;
        end
        return res;
    endfunction

    task automatic add_request(input logic kind, input logic [31:0] size,
                               input logic [31:0] addr, input bit hold);
        t_pending entry;
        entry.hold_for_drain      = hold;
        entry.req.kind            = kind;
        entry.req.request_size    = size;
        entry.req.release_address = addr;
        request_q.push_back(entry);
        requests_total++;
    endtask

    // filling bursts lean toward allocation, draining bursts toward frees
    task automatic queue_random(input bit filling, input bit hold);
        logic        kind;
        logic [31:0] size;
        logic [31:0] addr;
        int          pick;
        int          slot;
        int          offs;
        kind = ($urandom_range(99) < (filling ? 70 : 30)) ? KIND_ALLOC : KIND_FREE;
        size = $urandom;
        addr = $urandom;
        pick = $urandom_range(19);
        offs = 0;
        if (kind == KIND_ALLOC) begin
            if (pick == 0) begin
                size = 32'd0;
            end else if (pick == 1) begin
                size = LARGE_SLOT_BYTES_DEF + 1;
            end else if (pick == 2) begin
                size = $urandom | 32'h0000_0400;
            end else if (pick < 12) begin
                size = $urandom_range(SMALL_SLOT_BYTES_DEF, 1);
            end else begin
                size = $urandom_range(LARGE_SLOT_BYTES_DEF, SMALL_SLOT_BYTES_DEF + 1);
            end
        end else begin
            // picks 1 and 2 keep the stray random address
            if (pick == 0) begin
                addr = 32'd0;
            end else if (pick >= 12) begin
                slot = $urandom_range(LARGE_SLOTS_DEF - 1);
                if ($urandom_range(3) == 0) offs = $urandom_range(LARGE_SLOT_BYTES_DEF - 1);
                addr = large_base + slot * LARGE_SLOT_BYTES_DEF + offs;
            end else if (pick >= 3) begin
                slot = $urandom_range(SMALL_SLOTS_DEF - 1);
                if ($urandom_range(3) == 0) offs = $urandom_range(SMALL_SLOT_BYTES_DEF - 1);
                addr = small_base + slot * SMALL_SLOT_BYTES_DEF + offs;
            end
        end
        add_request(kind, size, addr, hold);
    endtask

    task automatic write_pool_base(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SMALL_BASE) begin
            small_base = val;
        end else begin
            large_base = val;
        end
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (request_q.size() != 0 || in_valid || outcome_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(posedge clk) begin : drive_requests
        logic next_valid;
        if (rst_n) begin
            next_valid = in_valid;
            if (in_valid && !in_stall) begin
                outcome_q.push_back(predict_outcome(in_item));
                next_valid = 1'b0;
            end
            if (!next_valid && request_q.size() != 0) begin
                if (request_q[0].hold_for_drain) begin
                    // sender holds off until every outstanding result is back
                    if (outcome_q.size() == 0) request_q[0].hold_for_drain = 1'b0;
                end else if ($urandom_range(99) >= send_idle_pct) begin
                    in_item <= request_q[0].req;
                    request_q.pop_front();
                    next_valid = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (outcome_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("result %0d with nothing pending: status %0d class %0d slot %0d addr %h",
                                 results_seen, out_item.status, out_item.pool_class,
                                 out_item.slot_index, out_item.granted_address);
                    end
                end else begin
                    want = outcome_q.pop_front();
                    if (want.status <= ST_FOREIGN) status_seen[want.status]++;
                    if (out_item.status !== want.status
                            || out_item.pool_class !== want.pool_class
                            || out_item.slot_index !== want.slot_index
                            || out_item.granted_address !== want.granted_address) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("result %0d: expected status %0d class %0d slot %0d addr %h, got status %0d class %0d slot %0d addr %h",
                                     results_seen, want.status, want.pool_class,
                                     want.slot_index, want.granted_address,
                                     out_item.status, out_item.pool_class,
                                     out_item.slot_index, out_item.granted_address);
                        end
                    end
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    initial begin : run_test
        int          ph;
        int          n;
        logic [31:0] base;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 14;
        recv_idle_pct = 57;
        @(negedge clk);

        // size edges, heap fallback, null and edge addresses at the reset bases
        add_request(KIND_ALLOC, 32'd0, $urandom, 1'b0);
        add_request(KIND_ALLOC, 32'd1, $urandom, 1'b0);
        add_request(KIND_ALLOC, SMALL_SLOT_BYTES_DEF, $urandom, 1'b0);
        add_request(KIND_ALLOC, SMALL_SLOT_BYTES_DEF + 1, $urandom, 1'b0);
        add_request(KIND_ALLOC, LARGE_SLOT_BYTES_DEF, $urandom, 1'b0);
        add_request(KIND_ALLOC, LARGE_SLOT_BYTES_DEF + 1, $urandom, 1'b0);
        add_request(KIND_ALLOC, 32'hFFFF_FFFF, $urandom, 1'b0);
        add_request(KIND_FREE, $urandom, 32'd0, 1'b0);
        // unaligned free, then the same slot again while already clear
        add_request(KIND_FREE, $urandom, SMALL_BASE_RST + SMALL_SLOT_BYTES_DEF + 5, 1'b0);
        add_request(KIND_FREE, $urandom, SMALL_BASE_RST + SMALL_SLOT_BYTES_DEF, 1'b0);
        add_request(KIND_FREE, $urandom, SMALL_BASE_RST + SMALL_SPAN - 1, 1'b0);
        add_request(KIND_FREE, $urandom, SMALL_BASE_RST + SMALL_SPAN, 1'b0);
        add_request(KIND_FREE, $urandom, LARGE_BASE_RST + LARGE_SPAN - 1, 1'b0);
        add_request(KIND_FREE, $urandom, LARGE_BASE_RST + LARGE_SPAN, 1'b0);
        add_request(KIND_FREE, $urandom, SMALL_BASE_RST - 1, 1'b0);
        add_request(KIND_FREE, $urandom, 32'hFFFF_FFFF, 1'b0);
        // two large slots taken above, six more fill the pool, the last one hits full
        for (n = 0; n < 7; n++) begin
            add_request(KIND_ALLOC, SMALL_SLOT_BYTES_DEF + 1 + n * 60, $urandom, 1'b0);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph == 2) begin
                send_idle_pct = 57;
                recv_idle_pct = 14;
            end else if (ph == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            case (ph)
                1: begin
                    // large pool ends exactly at the top of the address space
                    write_pool_base(CFG_SMALL_BASE, 32'd0);
                    write_pool_base(CFG_LARGE_BASE, 32'hFFFF_F000);
                end
                2: begin
                    // small pool clipped at the top, grants wrap
                    write_pool_base(CFG_SMALL_BASE, 32'hFFFF_FFFF);
                    write_pool_base(CFG_LARGE_BASE, 32'd0);
                end
                3: begin
                    write_pool_base(CFG_SMALL_BASE, 32'h0001_0000);
                    write_pool_base(CFG_LARGE_BASE, 32'h0001_0000);
                end
                4: begin
                    base = $urandom;
                    write_pool_base(CFG_SMALL_BASE, base);
                    write_pool_base(CFG_LARGE_BASE, base + 32'h0000_0200);
                end
                5: begin
                    write_pool_base(CFG_SMALL_BASE, SMALL_BASE_RST);
                    write_pool_base(CFG_LARGE_BASE, LARGE_BASE_RST);
                end
                default: ;
            endcase
            @(negedge clk);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                queue_random((n / BURST_LEN) % 2 == 0, n == ITEMS_PER_PHASE / 2);
            end
        end
        wait_drained();

        $display("%0d requests checked across %0d pool base settings and three idle patterns",
                 requests_total, PHASES);
        $display("done %0d, ignored %0d, pool full %0d, heap fallback %0d, foreign free %0d",
                 status_seen[ST_DONE], status_seen[ST_IGNORED], status_seen[ST_FULL],
                 status_seen[ST_HEAP], status_seen[ST_FOREIGN]);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("two_class_bitmap_slot_allocator: match");
        end else begin
            $display("two_class_bitmap_slot_allocator: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #(5_000_000);
        $display("two_class_bitmap_slot_allocator: mismatch");
        $finish;
    end

endmodule

FILE: filelist.f
sv/tcba_pkg.sv
sv/tcba_find.sv
sv/tcba_div.sv
sv/tcba_core.sv
sv/two_class_bitmap_slot_allocator.sv
tb/tb_two_class_bitmap_slot_allocator.sv
